>>> rtl/twcm_pkg.sv
// Shared types, constants and blackbody colour table of the tunable white colour mixer.
`timescale 1ns / 1ps

package twcm_pkg;

  // Attribute selector carried with every write beat.
  typedef enum logic [1:0] {
    CMD_POWER  = 2'd0,
    CMD_LEVEL  = 2'd1,
    CMD_MIREDS = 2'd2,
    CMD_UNSUP  = 2'd3
  } cmd_e;

  typedef logic [7:0] chan_t;

  // Serial multiply-divide lane: operand width and product width.
  localparam int unsigned MD_OPW = 9;
  localparam int unsigned MD_PW  = 2 * MD_OPW;

  // Kelvin divider: dividend width holds the mired numerator.
  localparam int unsigned KDIV_NW = 20;
  localparam int unsigned MIRED_W = 16;
  localparam logic [KDIV_NW-1:0] MIRED_NUM = 20'd1000000;

  // Clamped kelvin fits in 13 bits.
  localparam int unsigned KEL_W = 13;
  localparam logic [KEL_W-1:0] KELVIN_MIN = 13'd2000;
  localparam logic [KEL_W-1:0] KELVIN_MAX = 13'd6500;
  localparam logic [KEL_W-1:0] SEG_SPAN   = 13'd500;

  localparam logic [MD_OPW-1:0] SPAN_DIV  = 9'd500;
  localparam logic [MD_OPW-1:0] LEVEL_DIV = 9'd254;

  localparam int unsigned BB_POINTS = 10;
  localparam int unsigned SEG_W     = 4;

  // Blackbody points from 2000 K to 6500 K in 500 K steps: red, green, blue.
  localparam chan_t BB_TAB [0:BB_POINTS-1][0:2] = '{
    '{8'd255, 8'd141, 8'd11},
    '{8'd255, 8'd165, 8'd71},
    '{8'd255, 8'd180, 8'd107},
    '{8'd255, 8'd196, 8'd137},
    '{8'd255, 8'd209, 8'd163},
    '{8'd255, 8'd219, 8'd186},
    '{8'd255, 8'd228, 8'd206},
    '{8'd255, 8'd236, 8'd224},
    '{8'd255, 8'd243, 8'd239},
    '{8'd255, 8'd249, 8'd253}
  };

endpackage

>>> rtl/twcm_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module twcm_sdiv #(
  parameter int unsigned WN = 20,
  parameter int unsigned WD = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [WN-1:0] dividend_i,
  input  logic [WD-1:0] divisor_i,
  output logic          busy_o,
  output logic [WN-1:0] quot_o
);

  localparam int unsigned CW = (WN > 1) ? $clog2(WN) : 1;

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [WN-1:0] quo_q;
  logic [WD-1:0] rem_q;
  logic [WD-1:0] dsr_q;

  logic [WD:0]   trial;
  logic [WD:0]   diff;
  logic          take;
  logic [WD-1:0] rem_d;
  logic [WN-1:0] quo_d;

  // Bring down the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem_q, quo_q[WN-1]};
    diff  = trial - {1'b0, dsr_q};
    take  = (trial >= {1'b0, dsr_q});
    rem_d = take ? diff[WD-1:0] : trial[WD-1:0];
    quo_d = {quo_q[WN-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(WN - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_full_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> ($past(cnt_q) == '0))
    else $error("divider finished before the last quotient bit");

endmodule

>>> rtl/twcm_muldiv.sv
// Serial lane that forms (x * y) / d by shift-add multiply then restoring divide.
`timescale 1ns / 1ps

module twcm_muldiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [twcm_pkg::MD_OPW-1:0] x_i,
  input  logic [twcm_pkg::MD_OPW-1:0] y_i,
  input  logic [twcm_pkg::MD_OPW-1:0] div_i,
  output logic                        busy_o,
  output logic [twcm_pkg::MD_PW-1:0]  quot_o
);

  localparam int unsigned OPW = twcm_pkg::MD_OPW;
  localparam int unsigned PW  = twcm_pkg::MD_PW;
  localparam int unsigned CW  = $clog2(OPW);

  logic           mbusy_q;
  logic [CW-1:0]  mcnt_q;
  logic [PW-1:0]  acc_q;
  logic [PW-1:0]  mcand_q;
  logic [OPW-1:0] mplier_q;
  logic [OPW-1:0] dsr_q;

  logic [PW-1:0]  acc_nx;
  logic           div_start;
  logic           div_busy;

  always_comb begin
    acc_nx    = acc_q + (mplier_q[0] ? mcand_q : '0);
    div_start = mbusy_q && (mcnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mcnt_q  <= '0;
    end else if (start_i) begin
      mbusy_q <= 1'b1;
      mcnt_q  <= CW'(OPW - 1);
    end else if (mbusy_q) begin
      if (mcnt_q == '0) begin
        mbusy_q <= 1'b0;
      end else begin
        mcnt_q <= mcnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= PW'(x_i);
      mplier_q <= y_i;
      dsr_q    <= div_i;
    end else if (mbusy_q) begin
      acc_q    <= acc_nx;
      mcand_q  <= {mcand_q[PW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[OPW-1:1]};
    end
  end

  twcm_sdiv #(
    .WN (PW),
    .WD (OPW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_nx),
    .divisor_i  (dsr_q),
    .busy_o     (div_busy),
    .quot_o     (quot_o)
  );

  assign busy_o = mbusy_q | div_busy;

  a_phases_apart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mbusy_q |-> !div_busy)
    else $error("multiply and divide phases overlap");

endmodule

>>> rtl/tunable_white_color_mixer_top.sv
// Top level of the tunable white colour mixer: attribute store, sequencer and output register.
`timescale 1ns / 1ps

// The block receives attribute writes on a slave stream and answers each beat with one
// RGB pixel beat on a master stream. s_axis_tuser_i selects the attribute (on/off, level,
// colour temperature in mireds, or an unsupported one) and s_axis_tdata_i carries the value.
// The pixel leaves on m_axis_tdata_o with the lit and status flags on m_axis_tuser_o.
//
// Items are handled one at a time. A write that turns the pixel black, or an unsupported
// attribute, goes straight to the done state and reaches the output register once that
// register is free. A lit pixel goes through a bit-serial 1000000 / mireds divide
// alongside the level-squared gamma lane, a segment search, then two passes of three
// multiply-divide lanes (9 multiply and 18 divide steps each). Either way the next write
// is taken only once the result has left the sequencer for the output register.
//
// Reset clears the light to off with level 254 and 300 mireds, and empties the output
// register. The output register parts the two sides: once a result is loaded, the
// next write beat is accepted even while the receiver stalls; a finished result then
// waits in the sequencer, with the input held off, until the output register is taken.

module tunable_white_color_mixer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] red, [15:8] green, [23:16] blue
  output logic [1:0]  m_axis_tuser_o    // [0] lit, [1] status
);

  localparam int unsigned OPW = twcm_pkg::MD_OPW;
  localparam int unsigned PW  = twcm_pkg::MD_PW;
  localparam int unsigned KW  = twcm_pkg::KEL_W;
  localparam int unsigned SW  = twcm_pkg::SEG_W;
  localparam int unsigned NW  = twcm_pkg::KDIV_NW;
  localparam int unsigned MW  = twcm_pkg::MIRED_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KDIV,
    ST_SEG,
    ST_INTERP,
    ST_SCALE,
    ST_DONE
  } state_e;

  state_e state_q;

  // Stored attributes.
  logic          power_q, power_d;
  logic [7:0]    bright_q, bright_d;
  logic [MW-1:0] mireds_q, mireds_d;

  // Working registers of the sequencer.
  logic [KW-1:0]  pos_q;
  logic [SW-1:0]  seg_q;
  logic [OPW-1:0] gamma_q;
  twcm_pkg::chan_t res_q [0:2];
  logic           res_lit_q;
  logic           res_stat_q;

  logic        m_valid_q;
  logic [23:0] m_data_q;
  logic [1:0]  m_user_q;

  logic accept;
  logic supported;
  logic lit_next;
  logic kstart;
  logic gstart;

  logic          kdiv_busy;
  logic [NW-1:0] kdiv_quot;
  logic          gam_busy;
  logic [PW-1:0] gam_quot;

  logic [KW-1:0] kelvin;
  logic          seg_more;
  logic          out_free;

  logic           lane_start;
  logic [2:0]     lane_busy;
  logic [PW-1:0]  lane_quot [0:2];
  logic [OPW-1:0] lane_x [0:2];
  logic [OPW-1:0] lane_y;
  logic [OPW-1:0] lane_div;
  twcm_pkg::chan_t rgb [0:2];
  twcm_pkg::chan_t sat [0:2];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // Attribute update for the beat being accepted.
  always_comb begin
    power_d   = power_q;
    bright_d  = bright_q;
    mireds_d  = mireds_q;
    supported = 1'b1;
    case (twcm_pkg::cmd_e'(s_axis_tuser_i))
      twcm_pkg::CMD_POWER:  power_d  = s_axis_tdata_i[0];
      twcm_pkg::CMD_LEVEL:  bright_d = s_axis_tdata_i[7:0];
      twcm_pkg::CMD_MIREDS: mireds_d = s_axis_tdata_i;
      default:              supported = 1'b0;
    endcase
    lit_next = supported && power_d && (bright_d != 8'd0);
    gstart   = accept && lit_next;
    kstart   = gstart && (mireds_d != '0);
  end

  // Kelvin is taken as the top of the range for zero mireds, then clamped.
  always_comb begin
    if (mireds_q == '0) begin
      kelvin = twcm_pkg::KELVIN_MAX;
    end else if (kdiv_quot < NW'(twcm_pkg::KELVIN_MIN)) begin
      kelvin = twcm_pkg::KELVIN_MIN;
    end else if (kdiv_quot > NW'(twcm_pkg::KELVIN_MAX)) begin
      kelvin = twcm_pkg::KELVIN_MAX;
    end else begin
      kelvin = kdiv_quot[KW-1:0];
    end
  end

  assign seg_more = (pos_q > twcm_pkg::SEG_SPAN);

  // The same three lanes first interpolate, then apply the brightness scaling.
  assign lane_start = (state_q == ST_SEG && !seg_more) ||
                      (state_q == ST_INTERP && lane_busy == '0);
  assign lane_y     = (state_q == ST_SEG) ? pos_q[OPW-1:0] : gamma_q;
  assign lane_div   = (state_q == ST_SEG) ? twcm_pkg::SPAN_DIV : twcm_pkg::LEVEL_DIV;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    always_comb begin
      rgb[c] = twcm_pkg::BB_TAB[seg_q][c] + lane_quot[c][7:0];
      sat[c] = (lane_quot[c][PW-1:8] != '0) ? 8'hFF : lane_quot[c][7:0];
      if (state_q == ST_SEG) begin
        lane_x[c] = OPW'(twcm_pkg::BB_TAB[SW'(seg_q + 1'b1)][c]) -
                    OPW'(twcm_pkg::BB_TAB[seg_q][c]);
      end else begin
        lane_x[c] = OPW'(rgb[c]);
      end
    end

    twcm_muldiv u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lane_start),
      .x_i     (lane_x[c]),
      .y_i     (lane_y),
      .div_i   (lane_div),
      .busy_o  (lane_busy[c]),
      .quot_o  (lane_quot[c])
    );
  end

  twcm_sdiv #(
    .WN (NW),
    .WD (MW)
  ) u_kdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (kstart),
    .dividend_i (twcm_pkg::MIRED_NUM),
    .divisor_i  (mireds_d),
    .busy_o     (kdiv_busy),
    .quot_o     (kdiv_quot)
  );

  // Gamma = level * level / 254, worked out while the kelvin divide runs.
  twcm_muldiv u_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gstart),
    .x_i     (OPW'(bright_d)),
    .y_i     (OPW'(bright_d)),
    .div_i   (twcm_pkg::LEVEL_DIV),
    .busy_o  (gam_busy),
    .quot_o  (gam_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      power_q    <= 1'b0;
      bright_q   <= 8'd254;
      mireds_q   <= 16'd300;
      pos_q      <= '0;
      seg_q      <= '0;
      gamma_q    <= '0;
      res_q      <= '{default: '0};
      res_lit_q  <= 1'b0;
      res_stat_q <= 1'b0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= '0;
    end else begin
      // The output register is refilled from the sequencer or emptied by the receiver.
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            power_q  <= power_d;
            bright_q <= bright_d;
            mireds_q <= mireds_d;
            if (lit_next) begin
              state_q <= ST_KDIV;
            end else begin
              // Black pixel: light off, level zero or unsupported attribute.
              res_q      <= '{default: '0};
              res_lit_q  <= 1'b0;
              res_stat_q <= !supported;
              state_q    <= ST_DONE;
            end
          end
        end
        ST_KDIV: begin
          if (!kdiv_busy && !gam_busy) begin
            pos_q   <= kelvin - twcm_pkg::KELVIN_MIN;
            seg_q   <= '0;
            gamma_q <= gam_quot[OPW-1:0];
            state_q <= ST_SEG;
          end
        end
        ST_SEG: begin
          // Step down one 500 K segment per cycle.
          if (seg_more) begin
            pos_q <= pos_q - twcm_pkg::SEG_SPAN;
            seg_q <= seg_q + 1'b1;
          end else begin
            state_q <= ST_INTERP;
          end
        end
        ST_INTERP: begin
          if (lane_busy == '0) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (lane_busy == '0) begin
            res_q      <= sat;
            res_lit_q  <= 1'b1;
            res_stat_q <= 1'b0;
            state_q    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_data_q  <= {res_q[2], res_q[1], res_q[0]};
            m_user_q  <= {res_stat_q, res_lit_q};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_lit_accepted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> !m_axis_tuser_o[1])
    else $error("lit pixel flagged as unsupported");

  a_dark_is_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("unlit pixel carries colour");

  a_out_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("pixel beat changed while stalled");

endmodule
